@@ rtl/core/bdq_pkg.sv @@
`default_nettype none

package bdq_pkg;

    // operation codes carried in the kind field
    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_BACK   = 2'd2,
        KIND_QUERY      = 2'd3
    } t_kind;

    localparam int unsigned VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] t_value;

    // per-cell control from the top level
    typedef struct packed {
        logic shift;  // take the left neighbor's entry
        logic load;   // take the incoming value
        logic live;   // this cell holds a stored entry
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ rtl/core/bounded_deque_with_search.sv @@
`default_nettype none
// channel  | signals                                          | accepted when
// ---------+--------------------------------------------------+------------------
// input    | i_valid, o_ready, i_kind, i_value                | i_valid & o_ready
// result   | o_valid, i_ready, o_found, o_accepted,           | o_valid & i_ready
//          | o_entry_count, o_is_empty                        |
//
// one item per cycle while no result is stalled: all cells update and compare in the accepting cycle
// the result sits in an output register from the cycle after the item is accepted
// a new item is taken while that register is empty or being drained
// synchronous active-low reset empties the list and drops any pending result
// a stalled result holds o_ready low until i_ready returns

module bounded_deque_with_search #(
    parameter  int unsigned DEPTH = 16,
    localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // input channel
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_kind,
    input  wire logic signed [bdq_pkg::VALUE_W-1:0] i_value,
    // result channel
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_found,
    output logic               o_accepted,
    output logic [CW-1:0]      o_entry_count,
    output logic               o_is_empty
);

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    // occupancy counter
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // output register
    logic          r_out_valid;
    logic          r_found;
    logic          r_accepted;
    logic [CW-1:0] r_out_count;

    logic          w_fire;
    logic          w_full;
    logic          w_empty;
    logic          w_push_front;
    logic          w_push_back;
    logic          w_ok;
    logic          w_found;
    bdq_pkg::t_kind w_kind;

    bdq_pkg::t_value    w_data  [DEPTH];
    bdq_pkg::t_cell_ctl w_ctl   [DEPTH];
    logic [DEPTH-1:0]   w_match;

    assign w_fire  = i_valid && o_ready;
    assign w_full  = (r_count == FULL_COUNT);
    assign w_empty = (r_count == '0);
    assign w_kind  = bdq_pkg::t_kind'(i_kind);

    // decode the operation and its effect on the count
    always_comb begin
        w_push_front = 1'b0;
        w_push_back  = 1'b0;
        w_ok         = 1'b1;
        n_count      = r_count;
        case (w_kind)
            bdq_pkg::KIND_PUSH_FRONT: begin
                w_ok         = !w_full;
                w_push_front = w_fire && !w_full;
                if (!w_full) n_count = r_count + CW'(1);
            end
            bdq_pkg::KIND_PUSH_BACK: begin
                w_ok        = !w_full;
                w_push_back = w_fire && !w_full;
                if (!w_full) n_count = r_count + CW'(1);
            end
            bdq_pkg::KIND_POP_BACK: begin
                // pop only lowers the count; the stale cell is overwritten later
                w_ok = !w_empty;
                if (!w_empty) n_count = r_count - CW'(1);
            end
            bdq_pkg::KIND_QUERY: begin
                w_ok = 1'b1;
            end
            default: begin
                w_ok = 1'b1;
            end
        endcase
    end

    // row of cells, cell 0 is the front; a front insert shifts the whole row back
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_ctl[g].shift = w_push_front;
        assign w_ctl[g].load  = (w_push_front && (g == 0))
                             || (w_push_back && (r_count == CW'(g)));
        assign w_ctl[g].live  = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            bdq_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[g]),
                .i_left  (i_value),
                .i_value (i_value),
                .o_data  (w_data[g]),
                .o_match (w_match[g])
            );
        end else begin : g_body
            bdq_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[g]),
                .i_left  (w_data[g-1]),
                .i_value (i_value),
                .o_data  (w_data[g]),
                .o_match (w_match[g])
            );
        end
    end

    // match only counts for queries
    assign w_found = (w_kind == bdq_pkg::KIND_QUERY) && (|w_match);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_found     <= w_found;
            r_accepted  <= w_ok;
            r_out_count <= n_count;
        end
    end

    assign o_ready       = !r_out_valid || i_ready;
    assign o_valid       = r_out_valid;
    assign o_found       = r_found;
    assign o_accepted    = r_accepted;
    assign o_entry_count = r_out_count;
    assign o_is_empty    = (r_out_count == '0);

endmodule

`default_nettype wire

@@ rtl/core/bdq_cell.sv @@
`default_nettype none

module bdq_cell (
    input  wire logic              i_clk,
    input  wire bdq_pkg::t_cell_ctl i_ctl,
    input  wire bdq_pkg::t_value   i_left,
    input  wire bdq_pkg::t_value   i_value,
    output bdq_pkg::t_value        o_data,
    output logic                   o_match
);

    bdq_pkg::t_value r_data;
    bdq_pkg::t_value n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_value;
        end else if (i_ctl.shift) begin
            n_data = i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // local compare against the searched value
    assign o_match = i_ctl.live && (r_data == i_value);
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ rtl/core/bdq_checker.sv @@
`default_nettype none

module bdq_checker #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_valid,
    input wire logic          o_ready,
    input wire logic [1:0]    i_kind,
    input wire logic signed [bdq_pkg::VALUE_W-1:0] i_value,
    input wire logic          o_valid,
    input wire logic          i_ready,
    input wire logic          o_found,
    input wire logic          o_accepted,
    input wire logic [CW-1:0] o_entry_count,
    input wire logic          o_is_empty
);

    // empty flag agrees with the count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("is_empty disagrees with entry_count");

    // count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= CW'(DEPTH)))
        else $error("entry_count above depth");

    // a refused operation never reports a match
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> o_accepted)
        else $error("found on a refused item");

    // any accepted item shows up as a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> o_valid)
        else $error("accepted item produced no result");

endmodule

bind bounded_deque_with_search bdq_checker #(.DEPTH(DEPTH), .CW(CW)) u_bdq_checker (.*);

`default_nettype wire

@@ dv/bounded_deque_with_search_checker.sv @@
`timescale 1ns / 100ps

module bounded_deque_with_search_checker #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel as seen at the block
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [1:0]           i_kind,
    input  bdq_pkg::t_value      i_value,
    // result channel as seen at the block
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_found,
    input  logic                 i_accepted,
    input  logic [CW-1:0]        i_entry_count,
    input  logic                 i_is_empty,
    // status for the top
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_refused,
    output int                   o_hits
);

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic          found;
        logic          accepted;
        logic [CW-1:0] count;
        logic          is_empty;
    } t_outcome;

    // live entries, front of the list at index 0
    bdq_pkg::t_value stored[$];
    t_outcome        outcomes_due[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        o_fail_count++;
        if (o_fail_count <= MAX_PRINTED)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    function automatic t_outcome apply_op(input bdq_pkg::t_kind op,
                                          input bdq_pkg::t_value v);
        t_outcome res;
        res          = '0;
        res.accepted = 1'b1;
        case (op)
            bdq_pkg::KIND_PUSH_FRONT: begin
                if (stored.size() >= DEPTH) res.accepted = 1'b0;
                else stored.push_front(v);
            end
            bdq_pkg::KIND_PUSH_BACK: begin
                if (stored.size() >= DEPTH) res.accepted = 1'b0;
                else stored.push_back(v);
            end
            bdq_pkg::KIND_POP_BACK: begin
                if (stored.size() == 0) res.accepted = 1'b0;
                else void'(stored.pop_back());
            end
            default: begin
                foreach (stored[j])
                    if (stored[j] == v) res.found = 1'b1;
            end
        endcase
        res.count    = CW'(stored.size());
        res.is_empty = (stored.size() == 0);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_outcome due;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (outcomes_due.size() == 0) begin
                    report_mismatch("result with nothing due", 32'({i_found, i_accepted}),
                                    '0);
                end else begin
                    due = outcomes_due.pop_front();
                    o_checked++;
                    if (i_found !== due.found)
                        report_mismatch("found", 32'(i_found), 32'(due.found));
                    if (i_accepted !== due.accepted)
                        report_mismatch("accepted", 32'(i_accepted), 32'(due.accepted));
                    if (i_entry_count !== due.count)
                        report_mismatch("entry_count", 32'(i_entry_count), 32'(due.count));
                    if (i_is_empty !== due.is_empty)
                        report_mismatch("is_empty", 32'(i_is_empty), 32'(due.is_empty));
                end
            end
            if (i_in_valid && i_in_ready) begin
                due = apply_op(bdq_pkg::t_kind'(i_kind), i_value);
                if (!due.accepted) o_refused++;
                if (due.found) o_hits++;
                outcomes_due.push_back(due);
            end
            o_pending = outcomes_due.size();
        end
    end

endmodule

@@ dv/bounded_deque_with_search_tb.sv @@
`timescale 1ns / 100ps

module bounded_deque_with_search_tb;

    localparam int unsigned DEPTH        = 16;
    localparam int unsigned CW           = $clog2(DEPTH + 1);
    localparam int          RANDOM_ITEMS = 1800;
    localparam int          SETTLE       = 8;

    // traffic shapes for the random part
    typedef enum int {MOOD_FILL, MOOD_DRAIN, MOOD_MIXED} t_mood;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_ready;
    logic [1:0]      i_kind;
    bdq_pkg::t_value i_value;
    logic            o_valid;
    logic            i_ready;
    logic            o_found;
    logic            o_accepted;
    logic [CW-1:0]   o_entry_count;
    logic            o_is_empty;

    int fail_count;
    int pending;
    int checked;
    int refused;
    int hits;
    int sent;

    // values that recur so queries hit and duplicates pile up
    bdq_pkg::t_value value_pool[8];

    bounded_deque_with_search #(.DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found       (o_found),
        .o_accepted    (o_accepted),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty)
    );

    bounded_deque_with_search_checker #(.DEPTH(DEPTH)) u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_found       (o_found),
        .i_accepted    (o_accepted),
        .i_entry_count (o_entry_count),
        .i_is_empty    (o_is_empty),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_refused     (refused),
        .o_hits        (hits)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // reset asserted from time zero, released on a falling edge
    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: stalls follow their own pattern, independent of the sender
    initial begin : sink
        int mode;
        int len;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            mode = $urandom_range(0, 3);
            len  = (mode == 3) ? $urandom_range(1, 20) : $urandom_range(4, 40);
            repeat (len) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_ready <= 1'b1;                          // always ready
                    1:       i_ready <= ($urandom_range(0, 3) != 0);   // light stalls
                    2:       i_ready <= ($urandom_range(0, 1) != 0);   // heavy stalls
                    default: i_ready <= 1'b0;                          // long stall
                endcase
            end
        end
    end

    // present one item and hold it until the block takes it
    task automatic send_item(input bdq_pkg::t_kind op, input bdq_pkg::t_value v);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_kind  <= op;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    // drop valid for the given number of cycles, with junk on the payload
    task automatic idle(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            i_kind  <= 2'($urandom_range(0, 3));
            i_value <= bdq_pkg::t_value'($urandom);
        end
    endtask

    function automatic bdq_pkg::t_kind pick_kind(input t_mood mood);
        int r;
        r = $urandom_range(0, 99);
        case (mood)
            MOOD_FILL:  return (r < 40) ? bdq_pkg::KIND_PUSH_FRONT :
                               (r < 75) ? bdq_pkg::KIND_PUSH_BACK :
                               (r < 85) ? bdq_pkg::KIND_POP_BACK : bdq_pkg::KIND_QUERY;
            MOOD_DRAIN: return (r < 10) ? bdq_pkg::KIND_PUSH_FRONT :
                               (r < 20) ? bdq_pkg::KIND_PUSH_BACK :
                               (r < 75) ? bdq_pkg::KIND_POP_BACK : bdq_pkg::KIND_QUERY;
            default:    return bdq_pkg::t_kind'(r % 4);
        endcase
    endfunction

    // mostly recurring values, some small ones, the rest fully random
    function automatic bdq_pkg::t_value pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return value_pool[$urandom_range(0, 7)];
        if (r < 65) return bdq_pkg::t_value'($signed($urandom_range(0, 6)) - 3);
        return bdq_pkg::t_value'($urandom);
    endfunction

    initial begin : stimulus
        int    burst_left;
        int    phase_len;
        int    random_sent;
        t_mood mood;

        i_valid = 1'b0;
        i_kind  = bdq_pkg::KIND_QUERY;
        i_value = '0;
        value_pool[0] = '0;
        value_pool[1] = -1;
        value_pool[2] = 32'sh7fffffff;
        value_pool[3] = 32'sh80000000;
        for (int k = 4; k < 8; k++) value_pool[k] = bdq_pkg::t_value'($urandom);

        wait (i_rst_n === 1'b1);

        // directed: empty-store corner cases first
        send_item(bdq_pkg::KIND_QUERY, '0);                 // query on an empty store misses
        send_item(bdq_pkg::KIND_POP_BACK, -1);              // pop from empty is refused
        send_item(bdq_pkg::KIND_PUSH_FRONT, 32'sh7fffffff); // front insert into empty
        send_item(bdq_pkg::KIND_QUERY, 32'sh7fffffff);
        send_item(bdq_pkg::KIND_POP_BACK, '0);              // back to empty
        send_item(bdq_pkg::KIND_PUSH_BACK, 32'sh80000000);
        send_item(bdq_pkg::KIND_PUSH_FRONT, -1);
        send_item(bdq_pkg::KIND_QUERY, -1);
        send_item(bdq_pkg::KIND_QUERY, '0);                 // miss with entries present
        // fill to the top, with duplicates of -1 mixed in
        for (int k = 0; k < 14; k++)
            send_item((k % 2) ? bdq_pkg::KIND_PUSH_BACK : bdq_pkg::KIND_PUSH_FRONT,
                      (k % 3) ? bdq_pkg::t_value'($urandom) : bdq_pkg::t_value'(-1));
        // both pushes into a full store are refused
        send_item(bdq_pkg::KIND_PUSH_BACK, 32'sd5);
        send_item(bdq_pkg::KIND_PUSH_FRONT, 32'sd5);
        send_item(bdq_pkg::KIND_QUERY, 32'sh80000000);      // 80000000 entry still present after the fill

        // random: phases of fill, drain and mixed traffic in sender bursts
        random_sent = 0;
        burst_left  = 0;
        while (random_sent < RANDOM_ITEMS) begin
            mood      = t_mood'($urandom_range(0, 2));
            phase_len = $urandom_range(10, 40);
            repeat (phase_len) begin
                if (burst_left == 0) begin
                    if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                send_item(pick_kind(mood), pick_value());
                random_sent++;
            end
        end
        idle(1);

        // drain outstanding results, then give the block time to misbehave
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("run covered %0d items and %0d checked results", sent, checked);
        $display("%0d refused pushes or pops, %0d query hits", refused, hits);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
